/* design/ipv4mz_pkg.sv */
// Shared types, option codes and helpers for the IPv4 mutable-field zeroing block.
// No dependencies; every design file imports this package.
package ipv4mz_pkg;

    // Option type codes
    localparam logic [7:0] OPT_END_OF_LIST       = 8'd0;
    localparam logic [7:0] OPT_NO_OPERATION      = 8'd1;
    localparam logic [7:0] OPT_SECURITY          = 8'd130;
    localparam logic [7:0] OPT_EXT_SECURITY      = 8'd133;
    localparam logic [7:0] OPT_COMMERCIAL_SECURITY = 8'd134;
    localparam logic [7:0] OPT_ROUTER_ALERT      = 8'd148;
    localparam logic [7:0] OPT_DIRECTED_BCAST    = 8'd149;

    // Fixed header geometry
    localparam int          FIXED_HEADER_BYTES = 20;
    localparam logic [3:0]  MIN_IHL            = 4'd5;
    localparam logic [5:0]  DEFAULT_HDR_LEN    = 6'd20;

    // Queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] header_byte;
        logic       start_of_header;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_was_zeroed;
        logic       end_of_header;
    } out_item_t;

    // One parsed step: one result, or two when a held type byte is released
    typedef struct packed {
        logic      two;
        out_item_t first;
        out_item_t second;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic option_is_immutable(input logic [7:0] t);
        return (t == OPT_SECURITY)            || (t == OPT_EXT_SECURITY) ||
               (t == OPT_COMMERCIAL_SECURITY) || (t == OPT_ROUTER_ALERT) ||
               (t == OPT_DIRECTED_BCAST);
    endfunction

    function automatic out_item_t make_result(input logic [7:0] b, input logic z,
                                              input logic last);
        out_item_t r;
        r.out_byte        = z ? 8'd0 : b;
        r.byte_was_zeroed = z;
        r.end_of_header   = last;
        return r;
    endfunction

endpackage

/* design/ipv4_header_mutable_field_zeroing.sv */
// A byte's result passes through the queue and then the output register after acceptance;
// an option type byte gives no result until its length byte, which then gives two.
// One header byte per cycle while the queue is not full; the two-result step drains as two
// outputs, paid back by the silent type step, with a 4-entry queue absorbing the skew.
// Reset (rst_n, async, active low): parser at byte 0, header length 20, queue and
// output register empty.
module ipv4_header_mutable_field_zeroing
    import ipv4mz_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hdr_valid,
    output logic      hdr_ready,
    input  in_item_t  hdr,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res
);

    logic      accept;
    logic      push;
    q_entry_t  push_data;
    logic      pop;
    q_entry_t  head;
    q_status_t qstat;
    logic      pending;

    assign hdr_ready = !qstat.full;
    assign accept    = hdr_valid && hdr_ready;

    ipv4mz_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .hdr       (hdr),
        .push      (push),
        .push_data (push_data)
    );

    ipv4mz_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (qstat)
    );

    ipv4mz_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (qstat.empty),
        .pop       (pop),
        .pending   (pending),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // A zeroed byte always carries zero
    a_zeroed_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.byte_was_zeroed |-> res.out_byte == 8'd0)
        else $error("zeroed byte is nonzero");

    // No write into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue overflow");

    // Output drains when nothing is queued or pending
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && qstat.empty && !pending |=> !res_valid)
        else $error("result appeared from nothing");

endmodule

/* design/ipv4mz_front.sv */
// Parser front end: tracks header position and option state, one byte per cycle when accept is high.
// Depends on ipv4mz_pkg; feeds ipv4mz_queue with zero, one or two results per byte.
module ipv4mz_front
    import ipv4mz_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  hdr,
    output logic      push,
    output q_entry_t  push_data
);

    typedef enum logic [1:0] {
        MODE_TYPE,
        MODE_LEN,
        MODE_BODY,
        MODE_STOP
    } mode_t;

    logic [5:0] pos_reg, pos_next, pos_eff;
    logic [5:0] hlen_reg, hlen_next, hlen_eff;
    mode_t      mode_reg, mode_next, mode_eff;
    logic [7:0] held_reg, held_next, held_eff;
    logic [5:0] left_reg, left_next, left_eff, left_dec;
    logic       zopt_reg, zopt_next, zopt_eff;

    logic [7:0] b;
    logic [3:0] ihl_eff;
    logic       last;
    logic       fixed_zero;
    logic       imm_zero;
    logic       bad_len;
    logic [8:0] len_end;
    logic       res_one;
    logic       res_two;

    assign b = hdr.header_byte;

    // Per-byte parse decision
    always_comb
    begin
        pos_eff  = hdr.start_of_header ? 6'd0 : pos_reg;
        mode_eff = hdr.start_of_header ? MODE_TYPE : mode_reg;
        held_eff = hdr.start_of_header ? 8'd0 : held_reg;
        left_eff = hdr.start_of_header ? 6'd0 : left_reg;
        zopt_eff = hdr.start_of_header ? 1'b0 : zopt_reg;

        ihl_eff  = (b[3:0] < MIN_IHL) ? MIN_IHL : b[3:0];
        hlen_eff = (pos_eff == 6'd0) ? {ihl_eff, 2'b00} : hlen_reg;
        last     = ({1'b0, pos_eff} + 7'd1) >= {1'b0, hlen_eff};

        // TOS, flags/fragment offset, TTL, checksum
        fixed_zero = (pos_eff == 6'd1)  || (pos_eff == 6'd6)  || (pos_eff == 6'd7) ||
                     (pos_eff == 6'd8)  || (pos_eff == 6'd10) || (pos_eff == 6'd11);
        imm_zero   = !option_is_immutable(held_eff);
        len_end    = {3'b000, pos_eff} + {1'b0, b} - 9'd1;
        bad_len    = (b < 8'd2) || (len_end > {3'b000, hlen_eff});
        left_dec   = (left_eff != 6'd0) ? left_eff - 6'd1 : left_eff;

        pos_next  = last ? 6'd0 : pos_eff + 6'd1;
        hlen_next = hlen_eff;
        mode_next = mode_eff;
        held_next = held_eff;
        left_next = left_eff;
        zopt_next = zopt_eff;

        res_one          = 1'b0;
        res_two          = 1'b0;
        push_data.two    = 1'b0;
        push_data.first  = make_result(b, 1'b0, last);
        push_data.second = make_result(b, 1'b0, last);

        if ({1'b0, pos_eff} < 7'(FIXED_HEADER_BYTES))
        begin
            res_one         = 1'b1;
            push_data.first = make_result(b, fixed_zero, last);
        end
        else
        begin
            unique case (mode_eff)
                MODE_TYPE:
                begin
                    if (b == OPT_END_OF_LIST)
                    begin
                        mode_next = MODE_STOP;
                        res_one   = 1'b1;
                    end
                    else if (b == OPT_NO_OPERATION)
                    begin
                        res_one = 1'b1;
                    end
                    else if (last)
                    begin
                        mode_next = MODE_STOP;
                        res_one   = 1'b1;
                    end
                    else
                    begin
                        held_next = b;
                        mode_next = MODE_LEN;
                    end
                end
                MODE_LEN:
                begin
                    res_two       = 1'b1;
                    push_data.two = 1'b1;
                    if (bad_len)
                    begin
                        mode_next        = MODE_STOP;
                        push_data.first  = make_result(held_eff, 1'b0, 1'b0);
                        push_data.second = make_result(b, 1'b0, last);
                    end
                    else
                    begin
                        push_data.first  = make_result(held_eff, imm_zero, 1'b0);
                        push_data.second = make_result(b, imm_zero, last);
                        left_next        = b[5:0] - 6'd2;
                        zopt_next        = imm_zero;
                        mode_next        = (b[5:0] - 6'd2 != 6'd0) ? MODE_BODY : MODE_TYPE;
                    end
                end
                MODE_BODY:
                begin
                    res_one         = 1'b1;
                    push_data.first = make_result(b, zopt_eff, last);
                    left_next       = left_dec;
                    if (left_dec == 6'd0)
                    begin
                        mode_next = MODE_TYPE;
                    end
                end
                MODE_STOP:
                begin
                    res_one = 1'b1;
                end
                default:
                begin
                    res_one = 1'b1;
                end
            endcase
        end

        // Header complete: back to the start of the next header
        if (last)
        begin
            mode_next = MODE_TYPE;
            held_next = 8'd0;
            left_next = 6'd0;
            zopt_next = 1'b0;
        end
    end

    assign push = accept && (res_one || res_two);

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 6'd0;
            hlen_reg <= DEFAULT_HDR_LEN;
            mode_reg <= MODE_TYPE;
            held_reg <= 8'd0;
            left_reg <= 6'd0;
            zopt_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            hlen_reg <= hlen_next;
            mode_reg <= mode_next;
            held_reg <= held_next;
            left_reg <= left_next;
            zopt_reg <= zopt_next;
        end
    end

endmodule

/* design/ipv4mz_queue.sv */
// Short FIFO of parsed steps between the parser and the output stage.
// Depends on ipv4mz_pkg for the entry type and depth.
module ipv4mz_queue
    import ipv4mz_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_data,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    q_entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg;
    logic [QPTR_W-1:0]   rd_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign head         = mem[rd_reg];
    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

/* design/ipv4mz_back.sv */
// Output stage: unpacks one- or two-result queue entries into a registered result.
// Depends on ipv4mz_pkg; pops ipv4mz_queue.
module ipv4mz_back
    import ipv4mz_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_entry_t  head,
    input  logic      empty,
    output logic      pop,
    output logic      pending,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res
);

    logic      valid_reg, valid_next;
    logic      pend_reg, pend_next;
    out_item_t res_reg, res_next;
    out_item_t pend_data_reg, pend_data_next;
    logic      load;

    // Refill the output register whenever it is free or being taken
    always_comb
    begin
        load           = !valid_reg || res_ready;
        pop            = 1'b0;
        valid_next     = valid_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        pend_data_next = pend_data_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                res_next   = pend_data_reg;
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                valid_next     = 1'b1;
                res_next       = head.first;
                pend_next      = head.two;
                pend_data_next = head.second;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        pend_data_reg <= pend_data_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;
    assign pending   = pend_reg;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for ipv4_header_mutable_field_zeroing.
// Depends on ipv4mz_pkg (item structs, option codes, header geometry) and the DUT.
// A scoreboard class predicts the zeroed byte stream; tasks drive headers with idles.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4mz_pkg::*;

    // Scoreboard: per-byte parser state plus the queue of bytes still due
    class header_zeroing_model;
        typedef enum logic [1:0] {EXPECT_TYPE, EXPECT_LEN, IN_BODY, STOPPED} parse_mode_e;

        logic [5:0]  byte_pos;
        logic [5:0]  hdr_len;
        parse_mode_e mode;
        logic [7:0]  held_type;
        logic [5:0]  body_left;
        logic        zero_body;
        out_item_t   expected_bytes[$];
        int          errors;

        function new();
            restart();
            hdr_len = DEFAULT_HDR_LEN;
            errors  = 0;
        endfunction

        function void restart();
            byte_pos  = '0;
            mode      = EXPECT_TYPE;
            held_type = '0;
            body_left = '0;
            zero_body = 1'b0;
        endfunction

        function void push_expected(input logic [7:0] b, input logic z, input logic last);
            out_item_t r;
            r.out_byte        = z ? 8'd0 : b;
            r.byte_was_zeroed = z;
            r.end_of_header   = last;
            expected_bytes.push_back(r);
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Accepted input byte: advance the parser, queue zero, one or two results
        function void note_header_byte(input in_item_t it);
            logic [7:0] b;
            logic [3:0] ihl;
            logic       last;
            logic       z;
            int         pos;
            b = it.header_byte;
            if (it.start_of_header)
                restart();
            pos = byte_pos;
            if (pos == 0)
            begin
                ihl = b[3:0];
                if (ihl < MIN_IHL)
                    ihl = MIN_IHL;
                hdr_len = {ihl, 2'b00};
            end
            last = (pos + 1) >= int'(hdr_len);

            if (pos < FIXED_HEADER_BYTES)
            begin
                // TOS, flags/fragment offset, TTL and checksum are mutable
                push_expected(b, pos inside {1, 6, 7, 8, 10, 11}, last);
            end
            else
            begin
                case (mode)
                    EXPECT_TYPE:
                    begin
                        if (b == OPT_END_OF_LIST)
                        begin
                            mode = STOPPED;
                            push_expected(b, 1'b0, last);
                        end
                        else if (b == OPT_NO_OPERATION)
                            push_expected(b, 1'b0, last);
                        else if (last)
                        begin
                            // type with no room for a length: pass it and stop
                            mode = STOPPED;
                            push_expected(b, 1'b0, last);
                        end
                        else
                        begin
                            held_type = b;
                            mode      = EXPECT_LEN;
                        end
                    end
                    EXPECT_LEN:
                    begin
                        if (b < 8'd2 || (pos - 1) + int'(b) > int'(hdr_len))
                        begin
                            // bad length: release both bytes untouched, stop parsing
                            mode = STOPPED;
                            push_expected(held_type, 1'b0, 1'b0);
                            push_expected(b, 1'b0, last);
                        end
                        else
                        begin
                            z = !(held_type inside {OPT_SECURITY, OPT_EXT_SECURITY,
                                                    OPT_COMMERCIAL_SECURITY,
                                                    OPT_ROUTER_ALERT,
                                                    OPT_DIRECTED_BCAST});
                            push_expected(held_type, z, 1'b0);
                            push_expected(b, z, last);
                            body_left = 6'(b - 8'd2);
                            zero_body = z;
                            mode      = (body_left != 0) ? IN_BODY : EXPECT_TYPE;
                        end
                    end
                    IN_BODY:
                    begin
                        push_expected(b, zero_body, last);
                        if (body_left > 0)
                            body_left = body_left - 6'd1;
                        if (body_left == 0)
                            mode = EXPECT_TYPE;
                    end
                    default:
                        push_expected(b, 1'b0, last);
                endcase
            end

            if (last)
                restart();
            else
                byte_pos = 6'(pos + 1);
        endfunction

        function void report(input string what, input int want, input int got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        endfunction

        // Accepted result: compare field by field with the oldest expectation
        function void check_out_byte(input out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report("out_byte", want.out_byte, got.out_byte);
            if (got.byte_was_zeroed !== want.byte_was_zeroed)
                report("byte_was_zeroed", want.byte_was_zeroed, got.byte_was_zeroed);
            if (got.end_of_header !== want.end_of_header)
                report("end_of_header", want.end_of_header, got.end_of_header);
        endfunction
    endclass

    localparam int ITEM_TARGET = 1850;
    localparam int LONG_STALL  = 300;
    localparam int IDLE_PCT    = 27;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      hdr_valid = 1'b0;
    logic      hdr_ready;
    in_item_t  hdr       = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_item_t res;

    header_zeroing_model sb = new();

    int items_sent = 0;
    bit quiet      = 1'b0;
    bit stall_req  = 1'b0;

    ipv4_header_mutable_field_zeroing dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk)
    begin : receiver
        int stall_left;
        if (stall_left > 0)
        begin
            res_ready <= 1'b0;
            stall_left--;
        end
        else if (stall_req)
        begin
            stall_req = 1'b0;
            stall_left = LONG_STALL;
            res_ready <= 1'b0;
        end
        else
            res_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: note inputs first, then check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hdr_valid && hdr_ready)
                sb.note_header_byte(hdr);
            if (res_valid && res_ready)
                sb.check_out_byte(res);
        end
    end

    function automatic in_item_t hb(input logic [7:0] b, input logic s);
        in_item_t it;
        it.header_byte     = b;
        it.start_of_header = s;
        return it;
    endfunction

    function automatic logic [7:0] pick_option_type();
        case ($urandom_range(0, 7))
            0:       return OPT_SECURITY;
            1:       return OPT_EXT_SECURITY;
            2:       return OPT_COMMERCIAL_SECURITY;
            3:       return OPT_ROUTER_ALERT;
            4:       return OPT_DIRECTED_BCAST;
            default: return 8'($urandom_range(2, 255));
        endcase
    endfunction

    task automatic fill_random(ref in_item_t q[$], input int n);
        repeat (n)
            q.push_back(hb(8'($urandom), 1'b0));
    endtask

    // One header: mostly well-formed options, some bad lengths, cuts and filler
    task automatic build_random_header(ref in_item_t q[$]);
        int ihl;
        int hlen;
        int pos;
        int kind;
        int room;
        int len;
        logic [7:0] t;
        q.delete();
        ihl  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
        hlen = (ihl < 5 ? 5 : ihl) * 4;
        q.push_back(hb({4'($urandom), 4'(ihl)}, $urandom_range(0, 9) != 0));
        fill_random(q, 19);
        pos = 20;
        while (pos < hlen)
        begin
            kind = $urandom_range(0, 99);
            room = hlen - pos;
            if (kind < 12)
            begin
                q.push_back(hb(OPT_NO_OPERATION, 1'b0));
                pos++;
            end
            else if (kind < 17)
            begin
                q.push_back(hb(OPT_END_OF_LIST, 1'b0));
                fill_random(q, room - 1);
                pos = hlen;
            end
            else if (kind < 82)
            begin
                t = pick_option_type();
                q.push_back(hb(t, 1'b0));
                pos++;
                if (room > 1)
                begin
                    // occasionally cut right after a held type byte
                    if ($urandom_range(0, 24) == 0)
                        return;
                    len = ($urandom_range(0, 3) == 0) ? room
                                                      : $urandom_range(2, room < 10 ? room : 10);
                    q.push_back(hb(8'(len), 1'b0));
                    fill_random(q, len - 2);
                    pos += len - 1;
                end
            end
            else if (kind < 92)
            begin
                q.push_back(hb(pick_option_type(), 1'b0));
                pos++;
                if (room > 1)
                begin
                    len = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                               : $urandom_range(room + 1, 255);
                    q.push_back(hb(8'(len), 1'b0));
                    fill_random(q, room - 2);
                    pos = hlen;
                end
            end
            else
            begin
                fill_random(q, 1);
                pos++;
            end
        end
        // occasionally truncate; the next header restarts mid-way
        if ($urandom_range(0, 19) == 0)
            q = q[0:$urandom_range(0, q.size() - 2)];
    endtask

    task automatic send_item(input in_item_t it);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            hdr_valid <= 1'b0;
            @(posedge clk);
        end
        hdr_valid <= 1'b1;
        hdr       <= it;
        do
            @(posedge clk);
        while (!hdr_ready);
        items_sent++;
    endtask

    task automatic send_bytes(input in_item_t q[$]);
        foreach (q[i])
            send_item(q[i]);
    endtask

    // Stop offering and wait for the result queue to empty, with a bound
    task automatic wait_for_results(input int limit);
        int n;
        n = 0;
        hdr_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (sb.pending() != 0 && n < limit);
    endtask

    initial
    begin
        in_item_t q[$];
        int       i;
        bit       stall_done;
        bit       pause_done;
        stall_done = 1'b0;
        pause_done = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: IHL 6, extreme byte values, NOP, mutable option, end of list
        q.delete();
        q.push_back(hb(8'hF6, 1'b1));
        for (i = 1; i < 20; i++)
            q.push_back(hb((i % 2) ? 8'hFF : 8'h00, 1'b0));
        q.push_back(hb(OPT_NO_OPERATION, 1'b0));
        q.push_back(hb(8'h44, 1'b0));
        q.push_back(hb(8'd2, 1'b0));
        q.push_back(hb(OPT_END_OF_LIST, 1'b0));
        send_bytes(q);
        wait_for_results(5000);

        // Random headers, with noise bursts mixed in
        while (items_sent < ITEM_TARGET)
        begin
            quiet = (items_sent >= 700 && items_sent < 1000);
            if (!stall_done && items_sent >= 300)
            begin
                stall_req  = 1'b1;
                stall_done = 1'b1;
            end
            if (!pause_done && items_sent >= 1400)
            begin
                wait_for_results(5000);
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                q.delete();
                repeat ($urandom_range(1, 6))
                    q.push_back(hb(8'($urandom), 1'($urandom)));
            end
            else
                build_random_header(q);
            send_bytes(q);
        end
        quiet = 1'b0;

        wait_for_results(5000);
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected results never arrived, expected %0h, actual none",
                     $time, sb.pending(), sb.expected_bytes[0]);
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
